// ----- design/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and digit decode for the ascii integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int unsigned CH_WIDTH    = 8;
   localparam int unsigned VALUE_WIDTH = 64;
   localparam int unsigned DIGIT_WIDTH = 4;
   // product of accumulator and base plus digit needs four extra bits
   localparam int unsigned WIDE_WIDTH  = VALUE_WIDTH + 4;

   localparam logic [CH_WIDTH-1:0] CH_PLUS    = 8'h2b;
   localparam logic [CH_WIDTH-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CH_WIDTH-1:0] CH_DOT     = 8'h2e;
   localparam logic [CH_WIDTH-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_WIDTH-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_WIDTH-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_WIDTH-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CH_WIDTH-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_WIDTH-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CH_WIDTH-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CH_WIDTH-1:0] CH_UPPER_X = 8'h58;

   // ceiling is 2^63 - 1 for positive text, 2^63 for negative text
   localparam logic [WIDE_WIDTH-1:0] CEIL_POS =
      {{(WIDE_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [WIDE_WIDTH-1:0] CEIL_NEG =
      {{(WIDE_WIDTH-VALUE_WIDTH){1'b0}}, 1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [4:0] {
      PH_START    = 5'b00001,
      PH_SIGNED   = 5'b00010,
      PH_DIGITS   = 5'b00100,
      PH_FRACTION = 5'b01000,
      PH_ERROR    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                   hit;
      logic [DIGIT_WIDTH-1:0] val;
   } digit_type;

   function automatic digit_type digit_decode(input logic [CH_WIDTH-1:0] c,
                                              input logic                hex);
      digit_type d;
      logic [CH_WIDTH-1:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff  = c - CH_ZERO;
         d.hit = 1'b1;
         d.val = diff[DIGIT_WIDTH-1:0];
      end else if (hex && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         diff  = c - CH_LOWER_A + 8'd10;
         d.hit = 1'b1;
         d.val = diff[DIGIT_WIDTH-1:0];
      end else if (hex && c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         diff  = c - CH_UPPER_A + 8'd10;
         d.hit = 1'b1;
         d.val = diff[DIGIT_WIDTH-1:0];
      end
      return d;
   endfunction

endpackage

// ----- design/ascii_integer_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit
// Parses one signed decimal or 0x-prefixed hex integer from a byte stream.
// ----------------------------------------------------------------------------
// timing: a request lands in the input register; applying it updates the parse
// state, and applying the last request of a text loads the result register
// throughput: one request per cycle, set by the combinational shift-add check;
// a stalled result holds an end-of-text request in the input register
// reset: synchronous, clears the parse state and both valid flags
module ascii_integer_parser_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [aip_pkg::CH_WIDTH-1:0]      req_ch,
   input  logic                              req_last,
   input  logic                              req_text_empty,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic signed [aip_pkg::VALUE_WIDTH-1:0] rsp_value
);

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic [aip_pkg::CH_WIDTH-1:0] in_ch_ff;
   logic                         in_last_ff;
   logic                         in_empty_ff;

   // parse state
   aip_pkg::phase_type              phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic                            hex_ff, hex_in;
   logic [aip_pkg::VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                            seen_ff, seen_in;
   logic                            lzo_ff, lzo_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [aip_pkg::VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic gives_rsp;
   logic out_free;
   logic advance;

   aip_pkg::digit_type dec_dig;
   aip_pkg::digit_type cur_dig;

   // stepped state before end-of-text handling
   aip_pkg::phase_type              st_phase;
   logic                            st_neg, st_hex, st_seen, st_lzo;
   logic [aip_pkg::VALUE_WIDTH-1:0] st_acc;
   logic                            take;
   logic [aip_pkg::DIGIT_WIDTH-1:0] take_val;
   logic [aip_pkg::WIDE_WIDTH-1:0]  acc_wide;
   logic [aip_pkg::WIDE_WIDTH-1:0]  scaled;
   logic [aip_pkg::WIDE_WIDTH-1:0]  cand;
   logic [aip_pkg::WIDE_WIDTH-1:0]  ceiling;
   logic                            fits;
   logic                            final_ok;

   assign gives_rsp   = in_last_ff | in_empty_ff;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign advance     = in_valid_ff & (~gives_rsp | out_free);
   assign req_ready   = ~in_valid_ff | advance;
   assign in_valid_in = (in_valid_ff & ~advance) | req_valid;

   assign dec_dig = aip_pkg::digit_decode(in_ch_ff, 1'b0);
   assign cur_dig = aip_pkg::digit_decode(in_ch_ff, hex_ff);

   // acc*base + d <= ceiling, equivalent to the floor-divided bound
   assign acc_wide = {{(aip_pkg::WIDE_WIDTH-aip_pkg::VALUE_WIDTH){1'b0}}, acc_ff};
   assign scaled   = hex_ff ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
   assign cand     = scaled + {{(aip_pkg::WIDE_WIDTH-aip_pkg::DIGIT_WIDTH){1'b0}}, take_val};
   assign ceiling  = neg_ff ? aip_pkg::CEIL_NEG : aip_pkg::CEIL_POS;
   assign fits     = (cand <= ceiling);

   always_comb begin
      st_phase = phase_ff;
      st_neg   = neg_ff;
      st_hex   = hex_ff;
      st_acc   = acc_ff;
      st_seen  = seen_ff;
      st_lzo   = lzo_ff;
      take     = 1'b0;
      take_val = cur_dig.val;

      unique case (phase_ff) inside
         aip_pkg::PH_START, aip_pkg::PH_SIGNED: begin
            if (phase_ff == aip_pkg::PH_START &&
                (in_ch_ff == aip_pkg::CH_PLUS || in_ch_ff == aip_pkg::CH_MINUS)) begin
               st_neg   = (in_ch_ff == aip_pkg::CH_MINUS);
               st_phase = aip_pkg::PH_SIGNED;
            end else if (!dec_dig.hit) begin
               st_phase = aip_pkg::PH_ERROR;
            end else begin
               take     = 1'b1;
               take_val = dec_dig.val;
               st_lzo   = (dec_dig.val == '0);
            end
         end
         aip_pkg::PH_DIGITS: begin
            if (lzo_ff && (in_ch_ff == aip_pkg::CH_LOWER_X ||
                           in_ch_ff == aip_pkg::CH_UPPER_X)) begin
               st_hex  = 1'b1;
               st_acc  = '0;
               st_seen = 1'b0;
               st_lzo  = 1'b0;
            end else begin
               st_lzo = 1'b0;
               if (cur_dig.hit) begin
                  take = 1'b1;
               end else if (in_ch_ff == aip_pkg::CH_DOT && seen_ff) begin
                  st_phase = aip_pkg::PH_FRACTION;
               end else begin
                  st_phase = aip_pkg::PH_ERROR;
               end
            end
         end
         aip_pkg::PH_FRACTION: begin
            if (in_ch_ff != aip_pkg::CH_ZERO) begin
               st_phase = aip_pkg::PH_ERROR;
            end
         end
         aip_pkg::PH_ERROR: begin
            st_phase = aip_pkg::PH_ERROR;
         end
         default: begin
            st_phase = aip_pkg::PH_ERROR;
         end
      endcase

      if (take) begin
         if (fits) begin
            st_acc   = cand[aip_pkg::VALUE_WIDTH-1:0];
            st_seen  = 1'b1;
            st_phase = aip_pkg::PH_DIGITS;
         end else begin
            st_phase = aip_pkg::PH_ERROR;
         end
      end
   end

   assign final_ok = (st_phase == aip_pkg::PH_DIGITS && st_seen) ||
                     (st_phase == aip_pkg::PH_FRACTION);

   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      lzo_in       = lzo_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;

      if (advance) begin
         if (gives_rsp) begin
            // end of text: report and return to the start state
            phase_in     = aip_pkg::PH_START;
            neg_in       = 1'b0;
            hex_in       = 1'b0;
            acc_in       = '0;
            seen_in      = 1'b0;
            lzo_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = ~in_empty_ff & final_ok;
            if (!in_empty_ff && final_ok) begin
               rsp_value_in = st_neg ? ('0 - st_acc) : st_acc;
            end else begin
               rsp_value_in = '0;
            end
         end else begin
            phase_in = st_phase;
            neg_in   = st_neg;
            hex_in   = st_hex;
            acc_in   = st_acc;
            seen_in  = st_seen;
            lzo_in   = st_lzo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= aip_pkg::PH_START;
         neg_ff       <= 1'b0;
         hex_ff       <= 1'b0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         lzo_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         hex_ff       <= hex_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         lzo_ff       <= lzo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff    <= req_ch;
         in_last_ff  <= req_last;
         in_empty_ff <= req_text_empty;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_value = rsp_value_ff;

endmodule
